FILE: rtl/core/bfpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine package
// Shared widths, register indexes, operation codes and status types.
// ----------------------------------------------------------------------------
package bfpe_pkg;

	localparam int HASH_W    = 64;
	localparam int BC_W      = 17;
	localparam int HC_W      = 5;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_W     = BC_W;

	localparam logic [CFG_IDX_W-1:0] REG_BIT_COUNT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT = CFG_IDX_W'(1);

	localparam logic [BC_W-1:0] BC_RESET = 17'h10000;
	localparam logic [HC_W-1:0] HC_RESET = 5'd4;

	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_QUERY  = 1'b1;

	// Remainder unit: bits of the dividend retired per cycle
	localparam int DIG_BITS  = 8;
	localparam int DIV_STEPS = HASH_W / DIG_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

FILE: rtl/core/bfpe_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine channels
// Request channel (mode and two hashes) and response channel (query answer).
// ----------------------------------------------------------------------------
interface bfpe_req_if import bfpe_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              mode;
	logic [HASH_W-1:0] first_hash;
	logic [HASH_W-1:0] second_hash;

	modport source (output valid, mode, first_hash, second_hash, input ready);
	modport sink   (input valid, mode, first_hash, second_hash, output ready);
endinterface

interface bfpe_rsp_if import bfpe_pkg::*; ();
	logic valid;
	logic ready;
	logic maybe_present;

	modport source (output valid, maybe_present, input ready);
	modport sink   (input valid, maybe_present, output ready);
endinterface

FILE: rtl/core/bloom_filter_probe_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine
// Double-hashing Bloom filter: insert sets probed bits, query tests them.
// ----------------------------------------------------------------------------
// The engine handles one item at a time. Probe i addresses bit
// (first_hash + i*second_hash + i*i) mod 2^64 mod bit_count; the probe value
// is stepped by two 64-bit adds and reduced by a shared remainder unit that
// retires 8 dividend bits a cycle. Each probe on an insert runs launch,
// remainder steps and store write; a query adds the registered store read
// and a check of the bit read back, and stops at the first clear bit. After
// reset the store is swept to zero, one bit a cycle, over all BIT_CAPACITY
// entries, and no item is taken meanwhile; configuration writes are taken
// at any time but belong in idle periods. A bit_count of zero acts as one,
// one above BIT_CAPACITY acts as BIT_CAPACITY, and hash_count saturates at
// MAX_PROBES. The answer sits in an output register, so the engine goes back
// to idle while it waits.
// ----------------------------------------------------------------------------
module bloom_filter_probe_engine import bfpe_pkg::*; #(
	parameter int BIT_CAPACITY = 65536,
	parameter int MAX_PROBES   = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata,
	bfpe_req_if.sink             req,
	bfpe_rsp_if.source           rsp
);

	localparam int AW = (BIT_CAPACITY > 1) ? $clog2(BIT_CAPACITY) : 1;
	localparam int PW = $clog2(MAX_PROBES + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_NEXT = 3'd1;
	localparam logic [2:0] ST_MOD  = 3'd2;
	localparam logic [2:0] ST_READ = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0]        state_q;
	logic [BC_W-1:0]   bit_count_q;
	logic [HC_W-1:0]   hash_count_q;
	logic [BC_W-1:0]   mod_q;
	logic [PW-1:0]     n_q;
	logic [PW-1:0]     i_q;
	logic [HASH_W-1:0] c_q;
	logic [HASH_W-1:0] d_q;
	logic              mode_q;
	logic              hit_q;
	logic              out_valid_q;
	logic              present_q;

	logic [BC_W-1:0]   mod_eff;
	logic [PW-1:0]     probes_eff;
	logic              div_start;
	div_stat_t         div_stat;
	logic [BC_W-1:0]   div_rem;
	logic [AW-1:0]     st_addr;
	logic              st_we;
	logic              st_re;
	logic              st_rd;
	logic              clearing;
	logic              accept;
	logic              out_load;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_count_q  <= BC_RESET;
			hash_count_q <= HC_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIT_COUNT:  bit_count_q  <= cfg_wdata;
				REG_HASH_COUNT: hash_count_q <= cfg_wdata[HC_W-1:0];
				default: ;
			endcase
		end
	end

	// Effective modulus and probe count, saturated
	always_comb begin
		if (bit_count_q == '0) begin
			mod_eff = BC_W'(1);
		end else if (32'(bit_count_q) > 32'(BIT_CAPACITY)) begin
			mod_eff = BC_W'(BIT_CAPACITY);
		end else begin
			mod_eff = bit_count_q;
		end
		if (32'(hash_count_q) > 32'(MAX_PROBES)) begin
			probes_eff = PW'(MAX_PROBES);
		end else begin
			probes_eff = PW'(hash_count_q);
		end
	end

	assign accept    = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE) && !clearing;
	assign div_start = (state_q == ST_NEXT) && (i_q != n_q);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || rsp.ready);

	// Remainder is below the modulus, hence below capacity: widen, then trim
	always_comb begin
		logic [BC_W+AW-1:0] ext;
		ext     = {{AW{1'b0}}, div_rem};
		st_addr = ext[AW-1:0];
	end

	assign st_we = (state_q == ST_MOD) && div_stat.done && (mode_q == MODE_INSERT);
	assign st_re = (state_q == ST_MOD) && div_stat.done && (mode_q == MODE_QUERY);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			i_q     <= '0;
			n_q     <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						i_q     <= '0;
						n_q     <= probes_eff;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (i_q == n_q) begin
						state_q <= (mode_q == MODE_QUERY) ? ST_DONE : ST_IDLE;
					end else begin
						i_q     <= i_q + PW'(1);
						state_q <= ST_MOD;
					end
				end
				ST_MOD: begin
					if (div_stat.done) begin
						state_q <= (mode_q == MODE_QUERY) ? ST_READ : ST_NEXT;
					end
				end
				ST_READ: begin
					// Stop at the first clear bit
					state_q <= st_rd ? ST_NEXT : ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Probe value stepping: c += d, d += 2, with d starting at second_hash + 1
	always_ff @(posedge clk) begin
		if (accept) begin
			c_q    <= req.first_hash;
			d_q    <= req.second_hash + HASH_W'(1);
			mode_q <= req.mode;
			mod_q  <= mod_eff;
			hit_q  <= 1'b1;
		end else begin
			if (div_start) begin
				c_q <= c_q + d_q;
				d_q <= d_q + HASH_W'(2);
			end
			if ((state_q == ST_READ) && !st_rd) begin
				hit_q <= 1'b0;
			end
		end
	end

	// Output register: hold the answer until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			present_q <= hit_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.maybe_present = present_q;

	bfpe_mod_unit u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (c_q),
		.modulus  (mod_q),
		.stat     (div_stat),
		.rem      (div_rem)
	);

	bfpe_bit_store #(
		.DEPTH (BIT_CAPACITY),
		.AW    (AW)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.we       (st_we),
		.re       (st_re),
		.addr     (st_addr),
		.rd_data  (st_rd),
		.clearing (clearing)
	);

	// Probe counter never runs past the probe limit
	a_probe_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (i_q <= n_q))
		else $error("probe counter beyond probe count");

	// Every store access falls inside the active modulus
	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_we || st_re) |-> (div_rem < mod_q))
		else $error("store access outside bit_count");

	// Remainder unit reports completion only while the sequencer waits on it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_MOD))
		else $error("remainder done outside wait state");

	// A new answer appears only after a query finished
	a_rsp_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (mode_q == MODE_QUERY))
		else $error("answer loaded for an insert");

	// No item is taken while the store is being cleared
	a_no_accept_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !req.ready)
		else $error("item accepted during clearing sweep");

endmodule

FILE: rtl/core/bfpe_mod_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine remainder unit
// Restoring remainder of a 64-bit value by a 17-bit modulus, 8 bits a cycle.
// ----------------------------------------------------------------------------
module bfpe_mod_unit import bfpe_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [HASH_W-1:0] dividend,
	input  logic [BC_W-1:0]   modulus,
	output div_stat_t         stat,
	output logic [BC_W-1:0]   rem
);

	logic [HASH_W-1:0]    dvd_q;
	logic [BC_W-1:0]      rem_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [BC_W-1:0]      rem_nxt;

	// One digit: shift in eight dividend bits, compare and subtract after each
	always_comb begin
		logic [BC_W:0] r;
		r = {1'b0, rem_q};
		for (int k = 0; k < DIG_BITS; k++) begin
			r = {r[BC_W-1:0], dvd_q[HASH_W-1-k]};
			if (r >= {1'b0, modulus}) begin
				r = r - {1'b0, modulus};
			end
		end
		rem_nxt = r[BC_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << DIG_BITS;
			rem_q <= rem_nxt;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

FILE: rtl/core/bfpe_bit_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine bit store
// One-bit memory with registered read and a clearing sweep after reset.
// ----------------------------------------------------------------------------
module bfpe_bit_store #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic          re,
	input  logic [AW-1:0] addr,
	output logic          rd_data,
	output logic          clearing
);

	logic          mem_q [DEPTH];
	logic          rd_q;
	logic [AW-1:0] clr_addr_q;
	logic          clearing_q;

	// Sweep every entry to zero, one per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (clearing_q) begin
			mem_q[clr_addr_q] <= 1'b0;
		end else if (we) begin
			mem_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rd_q <= mem_q[addr];
		end
	end

	assign rd_data  = rd_q;
	assign clearing = clearing_q;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bloom filter probe engine testbench
// Drives insert and query items through the request channel and checks each
// query answer against a bit-level bench model or a directed expected answer.
// ----------------------------------------------------------------------------
// The run waits out the store sweep after reset and walks a short table of
// directed items and register writes: empty-store queries, all-ones hashes,
// zero hash_count, hash_count and bit_count above their limits, bit_count of
// zero and one, and a write to an unused register index. Random phases follow,
// each with its own register setting. Most items insert fresh keys or query
// keys inserted earlier in the phase; the rest are random queries and corner
// hashes. The sender runs in bursts with random gaps, and the receiver stalls
// on patterns of its own, once for a long stretch to back up the engine.
// ----------------------------------------------------------------------------
module tb_top;
	import bfpe_pkg::*;

	localparam int BIT_CAPACITY = 65536;
	localparam int MAX_PROBES   = 16;

	// Slowest item: a query at the maximum probe count, with margin
	localparam int ITEM_LATENCY = 11 * MAX_PROBES + 24;

	// Store sweep after reset, then the slowest item, a sender gap and a
	// receiver stall for every item, taken several times over
	localparam longint CYCLE_LIMIT = 2_000_000;

	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 210;
	localparam int LONG_HOLD       = 400;
	localparam int MAX_KEYS        = 512;
	localparam int MAX_REPORTS     = 40;

	localparam logic [HASH_W-1:0] ALL_ONES = {HASH_W{1'b1}};
	localparam logic [HASH_W-1:0] TOP_BIT  = {1'b1, {(HASH_W-1){1'b0}}};

	// Index that maps to no register
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(9);

	typedef enum bit {ROW_WRITE, ROW_ITEM} row_kind_t;

	typedef enum logic [1:0] {RX_STREAM, RX_PATTERN, RX_RANDOM} rx_style_t;

	typedef struct {
		row_kind_t             kind;
		logic [CFG_IDX_W-1:0]  reg_index;
		logic [CFG_W-1:0]      reg_value;
		logic                  mode;
		logic [HASH_W-1:0]     first;
		logic [HASH_W-1:0]     second;
		bit                    typed;
		bit                    answer;
	} row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_wdata;

	bfpe_req_if req_ch ();
	bfpe_rsp_if rsp_ch ();

	bloom_filter_probe_engine #(
		.BIT_CAPACITY (BIT_CAPACITY),
		.MAX_PROBES   (MAX_PROBES)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Bench copy of the filter: bit store and the two registers
	bit              filter_bits [0:BIT_CAPACITY-1];
	logic [BC_W-1:0] bit_count_reg  = BC_RESET;
	logic [HC_W-1:0] hash_count_reg = HC_RESET;

	// Query answers still owed by the engine, oldest first
	bit pending_answers [$];

	int     mismatch_count = 0;
	longint cycle_count    = 0;

	// Receiver state; the long hold is requested by the stimulus
	bit        hold_request   = 1'b0;
	int        hold_left      = 0;
	rx_style_t rx_style       = RX_STREAM;
	int        rx_style_left  = 0;
	logic [7:0] stall_pattern = 8'hFF;
	logic [2:0] pattern_pos   = '0;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TIMEOUT after %0d cycles, %0d answers outstanding",
				cycle_count, pending_answers.size());
			$display("FAIL bloom_filter_probe_engine");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= MAX_REPORTS)
			$display("MISMATCH @%0t: %s", $time, what);
	endtask

	// Walk the probes of one item over the bench store. An insert sets each
	// probed bit; a query answers 1 only if every probed bit is set.
	function automatic bit probe_filter(input logic mode,
			input logic [HASH_W-1:0] first, input logic [HASH_W-1:0] second);
		logic [HASH_W-1:0] span;
		logic [HASH_W-1:0] step;
		logic [HASH_W-1:0] sum;
		logic [HASH_W-1:0] slot;
		int                probes;
		bit                hit;
		// Zero bit_count acts as one, anything above capacity saturates
		if (bit_count_reg == '0)
			span = 64'd1;
		else if (bit_count_reg > BIT_CAPACITY)
			span = HASH_W'(BIT_CAPACITY);
		else
			span = HASH_W'(bit_count_reg);
		probes = (hash_count_reg > MAX_PROBES) ? MAX_PROBES : int'(hash_count_reg);
		hit = 1'b1;
		for (int i = 0; i < probes; i++) begin
			step = HASH_W'(i);
			sum  = first + step * second + step * step;
			slot = sum % span;
			if (mode == MODE_INSERT)
				filter_bits[int'(slot)] = 1'b1;
			else if (!filter_bits[int'(slot)])
				hit = 1'b0;
		end
		return hit;
	endfunction

	function automatic logic [HASH_W-1:0] random_hash();
		return {$urandom, $urandom};
	endfunction

	// Hashes at the edges: zero, all ones, tiny, top bit set
	function automatic logic [HASH_W-1:0] corner_hash();
		case ($urandom_range(0, 3))
			0: return '0;
			1: return ALL_ONES;
			2: return HASH_W'($urandom_range(0, 15));
			default: return random_hash() | TOP_BIT;
		endcase
	endfunction

	function automatic row_t reg_row(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_W-1:0] value);
		row_t r;
		r = '{ROW_WRITE, index, value, MODE_INSERT, '0, '0, 1'b0, 1'b0};
		return r;
	endfunction

	function automatic row_t item_row(input logic mode, input logic [HASH_W-1:0] first,
			input logic [HASH_W-1:0] second, input bit typed, input bit answer);
		row_t r;
		r = '{ROW_ITEM, REG_SPARE, '0, mode, first, second, typed, answer};
		return r;
	endfunction

	// Offer one item from a falling edge and hold it until taken. Valid is
	// left high so the caller can chain the next item without a gap.
	task automatic offer(input logic mode, input logic [HASH_W-1:0] first,
			input logic [HASH_W-1:0] second, input bit typed, input bit answer);
		bit predicted;
		req_ch.valid       <= 1'b1;
		req_ch.mode        <= mode;
		req_ch.first_hash  <= first;
		req_ch.second_hash <= second;
		do
			@(posedge clk);
		while (!req_ch.ready);
		predicted = probe_filter(mode, first, second);
		if (mode == MODE_QUERY)
			pending_answers.push_back(typed ? answer : predicted);
		@(negedge clk);
	endtask

	// Drop valid, drain every owed answer, then let a trailing insert finish
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(negedge clk);
		repeat (ITEM_LATENCY) @(negedge clk);
	endtask

	// Write one register and mirror it in the bench copy
	task automatic cfg_write(input logic [CFG_IDX_W-1:0] index,
			input logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
		if (index == REG_BIT_COUNT)
			bit_count_reg = value[BC_W-1:0];
		else if (index == REG_HASH_COUNT)
			hash_count_reg = value[HC_W-1:0];
	endtask

	// Check each answer taken against the oldest one owed
	always @(posedge clk) begin
		bit want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch($sformatf("answer %b with no query outstanding",
					rsp_ch.maybe_present));
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.maybe_present !== want)
					report_mismatch($sformatf("maybe_present got %b want %b",
						rsp_ch.maybe_present, want));
			end
		end
	end

	// Receiver: a long hold when asked, otherwise a randomly redrawn stall style
	always @(negedge clk) begin
		if (hold_left != 0) begin
			hold_left--;
			rsp_ch.ready <= 1'b0;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = LONG_HOLD - 1;
			rsp_ch.ready <= 1'b0;
		end else begin
			if (rx_style_left == 0) begin
				rx_style      = rx_style_t'($urandom_range(0, 2));
				// Keep one ready slot in the pattern so no stall is endless
				stall_pattern = 8'($urandom) | 8'h01;
				rx_style_left = $urandom_range(50, 600);
			end
			rx_style_left--;
			pattern_pos++;
			case (rx_style)
				RX_STREAM:  rsp_ch.ready <= 1'b1;
				RX_PATTERN: rsp_ch.ready <= stall_pattern[pattern_pos];
				default:    rsp_ch.ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	initial begin : stimulus
		row_t              directed_rows [$];
		row_t              row;
		logic [HASH_W-1:0] inserted_first [$];
		logic [HASH_W-1:0] inserted_second [$];
		logic [HASH_W-1:0] first;
		logic [HASH_W-1:0] second;
		logic [CFG_W-1:0]  bc_value;
		logic [CFG_W-1:0]  hc_value;
		logic              mode;
		int                burst_left;
		int                sel;
		int                k;

		// Known values on every input from time zero, with reset held low at first
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_index          = '0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.mode        = MODE_INSERT;
		req_ch.first_hash  = '0;
		req_ch.second_hash = '0;
		rsp_ch.ready       = 1'b0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part; the engine starts at bit_count 65536, hash_count 4
		// Empty store: nothing can be present
		directed_rows.push_back(item_row(MODE_QUERY, '0, '0, 1'b1, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, ALL_ONES, ALL_ONES, 1'b1, 1'b0));
		// Insert then query the same key: always a hit
		directed_rows.push_back(item_row(MODE_INSERT, '0, '0, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, '0, '0, 1'b1, 1'b1));
		directed_rows.push_back(item_row(MODE_INSERT, ALL_ONES, ALL_ONES, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, ALL_ONES, ALL_ONES, 1'b1, 1'b1));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h8000_0000_0000_0000, 64'd1,
			1'b0, 1'b0));
		// No probes: insert is a no-op, every query answers present
		directed_rows.push_back(reg_row(REG_HASH_COUNT, CFG_W'(0)));
		directed_rows.push_back(item_row(MODE_INSERT, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h0123_4567_89AB_CDEF,
			64'hFEDC_BA98_7654_3210, 1'b1, 1'b1));
		// Hash count above the limit saturates to the maximum probe count
		directed_rows.push_back(reg_row(REG_HASH_COUNT, CFG_W'(31)));
		directed_rows.push_back(item_row(MODE_INSERT, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 1'b1));
		directed_rows.push_back(item_row(MODE_QUERY, '0, '0, 1'b0, 1'b0));
		// Zero bit count acts as one: every probe lands on bit 0, already set
		directed_rows.push_back(reg_row(REG_BIT_COUNT, CFG_W'(0)));
		directed_rows.push_back(item_row(MODE_QUERY, ALL_ONES, 64'h1234, 1'b1, 1'b1));
		directed_rows.push_back(item_row(MODE_INSERT, 64'hDEAD_BEEF_0000_0001,
			64'hBEEF_DEAD_FFFF_FFFE, 1'b0, 1'b0));
		directed_rows.push_back(reg_row(REG_BIT_COUNT, CFG_W'(1)));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h0F0F_0F0F_0F0F_0F0F,
			64'h7777_7777_7777_7777, 1'b1, 1'b1));
		// Bit count above capacity saturates; old bits stay in place
		directed_rows.push_back(reg_row(REG_BIT_COUNT, {CFG_W{1'b1}}));
		directed_rows.push_back(item_row(MODE_QUERY, '0, '0, 1'b0, 1'b0));
		// Unused index: ignored, so bit_count keeps the saturated value
		directed_rows.push_back(reg_row(REG_SPARE, CFG_W'(3)));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h5555_5555_5555_5555,
			64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0));
		directed_rows.push_back(reg_row(REG_BIT_COUNT, CFG_W'(BIT_CAPACITY)));
		directed_rows.push_back(reg_row(REG_HASH_COUNT, CFG_W'(MAX_PROBES)));
		directed_rows.push_back(item_row(MODE_INSERT, 64'h0000_0000_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, 64'h0000_0000_FFFF_FFFF,
			64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1));
		directed_rows.push_back(reg_row(REG_BIT_COUNT, CFG_W'(3)));
		directed_rows.push_back(reg_row(REG_HASH_COUNT, CFG_W'(1)));
		directed_rows.push_back(item_row(MODE_INSERT, 64'd2, '0, 1'b0, 1'b0));
		directed_rows.push_back(item_row(MODE_QUERY, 64'd5, 64'd7, 1'b0, 1'b0));

		foreach (directed_rows[i]) begin
			row = directed_rows[i];
			if (row.kind == ROW_WRITE) begin
				wait_idle();
				cfg_write(row.reg_index, row.reg_value);
			end else begin
				offer(row.mode, row.first, row.second, row.typed, row.answer);
			end
		end

		// Random phases, each under its own register setting
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_idle();
			case (phase)
				0: begin
					bc_value = CFG_W'(BIT_CAPACITY);
					hc_value = CFG_W'(MAX_PROBES);
				end
				1: begin
					bc_value = {CFG_W{1'b1}};
					hc_value = CFG_W'(31);
				end
				2: begin
					bc_value = CFG_W'($urandom_range(1, 64));
					hc_value = CFG_W'($urandom_range(1, 8));
				end
				3: begin
					bc_value = CFG_W'(0);
					hc_value = CFG_W'($urandom_range(0, 16));
				end
				default: begin
					bc_value = ($urandom_range(0, 1) != 0) ? CFG_W'($urandom_range(1, 256))
						: CFG_W'($urandom);
					hc_value = CFG_W'($urandom_range(0, 20));
				end
			endcase
			cfg_write(REG_BIT_COUNT, bc_value);
			cfg_write(REG_HASH_COUNT, hc_value);
			inserted_first.delete();
			inserted_second.delete();

			// Every third phase streams in long bursts, up to 400 items, between sender gaps
			burst_left = $urandom_range(1, (phase % 3 == 2) ? 400 : 24);
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				// Back up the engine once: receiver holds while items keep coming
				if (phase == 1 && n == 30)
					hold_request = 1'b1;

				sel = $urandom_range(0, 99);
				if (sel < 40) begin
					mode   = MODE_INSERT;
					first  = random_hash();
					second = random_hash();
					if (inserted_first.size() < MAX_KEYS) begin
						inserted_first.push_back(first);
						inserted_second.push_back(second);
					end
				end else if (sel < 75 && inserted_first.size() != 0) begin
					mode   = MODE_QUERY;
					k      = $urandom_range(0, inserted_first.size() - 1);
					first  = inserted_first[k];
					second = inserted_second[k];
				end else if (sel < 92) begin
					mode   = MODE_QUERY;
					first  = random_hash();
					second = random_hash();
				end else begin
					mode   = ($urandom_range(0, 1) != 0) ? MODE_QUERY : MODE_INSERT;
					first  = corner_hash();
					second = corner_hash();
				end
				offer(mode, first, second, 1'b0, 1'b0);

				burst_left--;
				if (burst_left == 0) begin
					req_ch.valid <= 1'b0;
					repeat ($urandom_range(1, 12)) @(negedge clk);
					burst_left = $urandom_range(1, (phase % 3 == 2) ? 400 : 24);
				end
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("PASS bloom_filter_probe_engine");
		else
			$display("FAIL bloom_filter_probe_engine");
		$finish;
	end

endmodule
